@@ rtl/talp_pkg.sv @@
// ----------------------------------------------------------------------------
// talp_pkg
// Shared widths and reset constants for the three-axis adaptive low-pass core.
// ----------------------------------------------------------------------------
package talp_pkg;

    // Default sample width and alpha fraction width
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int ALPHA_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int TAU_WIDTH = 20;
    localparam int DT_WIDTH  = 16;
    localparam int OUT_WIDTH = 32;

    // Denominator tau + dt, and the running remainder of the divide
    localparam int DEN_WIDTH = TAU_WIDTH + 1;

    // Time constant after reset, about 1/(2*pi*5 Hz) in microseconds
    localparam logic [TAU_WIDTH-1:0] TAU_RESET = TAU_WIDTH'(31831);

endpackage

@@ rtl/talp_sample_if.sv @@
// ----------------------------------------------------------------------------
// talp_sample_if
// Valid/ready channel carrying one three-axis sample and its elapsed time.
// ----------------------------------------------------------------------------
interface talp_sample_if #(
    parameter int SAMPLE_BITS = talp_pkg::SAMPLE_BITS_DEF
);
    import talp_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
    logic        [DT_WIDTH-1:0]    elapsed_us;

    modport source (
        output valid, sample_x, sample_y, sample_z, elapsed_us,
        input  ready
    );

    modport sink (
        input  valid, sample_x, sample_y, sample_z, elapsed_us,
        output ready
    );
endinterface

@@ rtl/talp_result_if.sv @@
// ----------------------------------------------------------------------------
// talp_result_if
// Valid/ready channel carrying the three filtered axis values.
// ----------------------------------------------------------------------------
interface talp_result_if;
    import talp_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] filtered_x;
    logic signed [OUT_WIDTH-1:0] filtered_y;
    logic signed [OUT_WIDTH-1:0] filtered_z;

    modport source (
        output valid, filtered_x, filtered_y, filtered_z,
        input  ready
    );

    modport sink (
        input  valid, filtered_x, filtered_y, filtered_z,
        output ready
    );
endinterface

@@ rtl/three_axis_adaptive_low_pass_core.sv @@
// ----------------------------------------------------------------------------
// three_axis_adaptive_low_pass_core
// First-order IIR low-pass on three axes with alpha = dt/(tau+dt), Q16.16.
// ----------------------------------------------------------------------------
// Sequence: an input transfer is followed by the bit-serial restoring divide for
//   alpha, the bit-serial multiply, the final add and the output register; the
//   output step waits while the output register holds a result not yet taken.
//   A new sample is taken only once the previous result is in the output register.
// Reset (synchronous, active low): held values clear to zero, tau returns
//   to 31831 us, the output channel goes empty.
module three_axis_adaptive_low_pass_core #(
    parameter int SAMPLE_BITS     = talp_pkg::SAMPLE_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = talp_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [talp_pkg::TAU_WIDTH-1:0]   i_cfg_wr_data,
    talp_sample_if.sink                      i_sample,
    talp_result_if.source                    o_result
);
    import talp_pkg::*;

    localparam int FRAC_BITS = OUT_WIDTH - SAMPLE_BITS;
    localparam int CNT_W     = $clog2(ALPHA_FRAC_BITS);
    localparam int DIFF_W    = OUT_WIDTH + 1;
    localparam int ACC_W     = OUT_WIDTH + 2;
    localparam int SUM_W     = ACC_W + 1;
    localparam int NUM_AXES  = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_ADD,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [TAU_WIDTH-1:0]            r_tau;
    logic [DEN_WIDTH-1:0]            r_den;
    logic [DEN_WIDTH-1:0]            r_rem;
    logic [ALPHA_FRAC_BITS-1:0]      r_quo;
    logic [CNT_W-1:0]                r_cnt;
    logic signed [OUT_WIDTH-1:0]     r_held [NUM_AXES];
    logic signed [DIFF_W-1:0]        r_diff [NUM_AXES];
    logic signed [ACC_W-1:0]         r_acc  [NUM_AXES];
    logic                            r_out_valid;
    logic signed [OUT_WIDTH-1:0]     r_out  [NUM_AXES];

    logic [TAU_WIDTH-1:0]            tau_eff;
    logic [DEN_WIDTH:0]              rem_shift;
    logic                            quo_bit;
    logic [DEN_WIDTH-1:0]            n_rem;
    logic signed [OUT_WIDTH-1:0]     target [NUM_AXES];
    logic signed [DIFF_W-1:0]        n_diff [NUM_AXES];
    logic signed [SUM_W-1:0]         mul_sum [NUM_AXES];
    logic signed [ACC_W-1:0]         n_acc  [NUM_AXES];
    logic signed [OUT_WIDTH-1:0]     n_held [NUM_AXES];
    logic                            in_xfer;
    logic                            out_free;

    // Handshakes
    assign i_sample.ready = (r_state == S_IDLE);
    assign in_xfer        = i_sample.valid && i_sample.ready;
    assign out_free       = !r_out_valid || o_result.ready;

    assign o_result.valid      = r_out_valid;
    assign o_result.filtered_x = r_out[0];
    assign o_result.filtered_y = r_out[1];
    assign o_result.filtered_z = r_out[2];

    // Treat a zero time constant as one
    assign tau_eff = (r_tau == '0) ? TAU_WIDTH'(1) : r_tau;

    // Restoring divide step: one quotient bit per cycle
    always_comb begin
        rem_shift = {r_rem, 1'b0};
        quo_bit   = (rem_shift >= {1'b0, r_den});
        if (quo_bit) begin
            n_rem = DEN_WIDTH'(rem_shift - {1'b0, r_den});
        end else begin
            n_rem = rem_shift[DEN_WIDTH-1:0];
        end
    end

    // Per-axis lanes: target difference, shift-right multiply step, final add
    always_comb begin
        target[0] = {i_sample.sample_x, {FRAC_BITS{1'b0}}};
        target[1] = {i_sample.sample_y, {FRAC_BITS{1'b0}}};
        target[2] = {i_sample.sample_z, {FRAC_BITS{1'b0}}};
        for (int k = 0; k < NUM_AXES; k++) begin
            n_diff[k] = DIFF_W'(target[k]) - DIFF_W'(r_held[k]);
            if (r_quo[0]) begin
                mul_sum[k] = SUM_W'(r_acc[k]) + SUM_W'(r_diff[k]);
            end else begin
                mul_sum[k] = SUM_W'(r_acc[k]);
            end
            // Arithmetic shift right by one drops the low bit: floor at each step
            n_acc[k]  = mul_sum[k][SUM_W-1:1];
            n_held[k] = r_held[k] + r_acc[k][OUT_WIDTH-1:0];
        end
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tau       <= TAU_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_held[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_tau <= i_cfg_wr_data;
            end

            // Drop the result once the sink takes it
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_den <= DEN_WIDTH'(tau_eff) + DEN_WIDTH'(i_sample.elapsed_us);
                        // dt < tau + dt, so the integer quotient bits are all zero
                        r_rem <= DEN_WIDTH'(i_sample.elapsed_us);
                        r_cnt <= CNT_W'(ALPHA_FRAC_BITS - 1);
                        for (int k = 0; k < NUM_AXES; k++) begin
                            r_diff[k] <= n_diff[k];
                        end
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[ALPHA_FRAC_BITS-2:0], quo_bit};
                    if (r_cnt == '0) begin
                        r_cnt <= CNT_W'(ALPHA_FRAC_BITS - 1);
                        for (int k = 0; k < NUM_AXES; k++) begin
                            r_acc[k] <= '0;
                        end
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_MUL: begin
                    // Consume alpha LSB first
                    r_quo <= {1'b0, r_quo[ALPHA_FRAC_BITS-1:1]};
                    for (int k = 0; k < NUM_AXES; k++) begin
                        r_acc[k] <= n_acc[k];
                    end
                    if (r_cnt == '0) begin
                        r_state <= S_ADD;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_ADD: begin
                    for (int k = 0; k < NUM_AXES; k++) begin
                        r_held[k] <= n_held[k];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        for (int k = 0; k < NUM_AXES; k++) begin
                            r_out[k] <= r_held[k];
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/talp_filter_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// talp_filter_check
// Watches the sample and result channels of the three-axis low-pass core,
// predicts the filtered Q16.16 values of every sample transfer and compares
// each result transfer against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module talp_filter_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [talp_pkg::TAU_WIDTH-1:0] i_cfg_wr_data,
    talp_sample_if                         i_sample,
    talp_result_if                         i_result,
    output int                             o_mismatches,
    output int                             o_pending
);
    import talp_pkg::*;

    localparam int FRAC_SHIFT = OUT_WIDTH - SAMPLE_BITS_DEF;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] x;
        logic signed [OUT_WIDTH-1:0] y;
        logic signed [OUT_WIDTH-1:0] z;
    } axes_t;

    logic [TAU_WIDTH-1:0] tau_us;
    longint               held_x;
    longint               held_y;
    longint               held_z;
    axes_t                filtered_q[$];
    int                   mismatch_count = 0;

    // alpha = floor(dt * 2^16 / (tau + dt)), a zero tau counts as one
    function automatic longint smoothing_factor(input logic [TAU_WIDTH-1:0] tau,
                                                input logic [DT_WIDTH-1:0]  dt);
        longint tau_eff;
        tau_eff = (tau == '0) ? 64'sd1 : longint'(tau);
        return (longint'(dt) << ALPHA_FRAC_BITS_DEF) / (tau_eff + longint'(dt));
    endfunction

    // Move one held value toward the scaled sample, floor on the shift
    function automatic longint blend_axis(input longint                             held,
                                          input logic signed [SAMPLE_BITS_DEF-1:0] raw,
                                          input longint                             alpha);
        longint target;
        longint diff;
        target = longint'(raw) <<< FRAC_SHIFT;
        diff   = target - held;
        return held + ((alpha * diff) >>> ALPHA_FRAC_BITS_DEF);
    endfunction

    function automatic void compare_axis(input string                       axis,
                                         input logic signed [OUT_WIDTH-1:0] want,
                                         input logic signed [OUT_WIDTH-1:0] got);
        if (got !== want) begin
            $display("%0t: filtered_%s expected %0d (0x%08h), got %0d (0x%08h)",
                     $time, axis, want, want, got, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : track
        axes_t  want;
        longint alpha;
        if (!i_rst_n) begin
            tau_us = TAU_RESET;
            held_x = 0;
            held_y = 0;
            held_z = 0;
            filtered_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                tau_us = i_cfg_wr_data;
            end

            // Compare each result transfer against the oldest prediction
            if (i_result.valid && i_result.ready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: result with none expected: x %0d y %0d z %0d", $time,
                             i_result.filtered_x, i_result.filtered_y, i_result.filtered_z);
                    mismatch_count++;
                end else begin
                    want = filtered_q.pop_front();
                    compare_axis("x", want.x, i_result.filtered_x);
                    compare_axis("y", want.y, i_result.filtered_y);
                    compare_axis("z", want.z, i_result.filtered_z);
                end
            end

            // Advance the filter state on each sample transfer
            if (i_sample.valid && i_sample.ready) begin
                alpha  = smoothing_factor(tau_us, i_sample.elapsed_us);
                held_x = blend_axis(held_x, i_sample.sample_x, alpha);
                held_y = blend_axis(held_y, i_sample.sample_y, alpha);
                held_z = blend_axis(held_z, i_sample.sample_z, alpha);
                want.x = OUT_WIDTH'(held_x);
                want.y = OUT_WIDTH'(held_y);
                want.z = OUT_WIDTH'(held_z);
                filtered_q.push_back(want);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= filtered_q.size();
    end

endmodule

@@ tb/three_axis_adaptive_low_pass_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_axis_adaptive_low_pass_core_test
// Drives samples and time constants into the three-axis low-pass core under
// random sender gaps and receiver stalls, including long output hold-offs,
// and reports the verdict from the filter checker's mismatch count.
// ----------------------------------------------------------------------------
module three_axis_adaptive_low_pass_core_test;
    import talp_pkg::*;

    localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 2 * ALPHA_FRAC_BITS_DEF + 3 + 25;
    localparam int SEGMENT_ITEMS   = 305;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [DT_WIDTH-1:0]        elapsed_t;

    localparam sample_t  SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam sample_t  SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam elapsed_t DT_MAX     = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [TAU_WIDTH-1:0] cfg_wr_data;
    int                   sender_idle_pct;
    int                   receiver_idle_pct;
    int                   hold_off_requests;
    int                   mismatches;
    int                   pending;
    int                   idle_cycles;

    talp_sample_if smp ();
    talp_result_if res ();

    three_axis_adaptive_low_pass_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_sample      (smp),
        .o_result      (res)
    );

    talp_filter_check u_filter_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_sample      (smp),
        .i_result      (res),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result receiver: random stalls, plus long hold-offs on request
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_seen != hold_off_requests) begin
                hold_seen = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // End the run when nothing transfers for too long
    always @(posedge clk) begin
        if ((smp.valid && smp.ready) || (res.valid && res.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(15))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            default: return sample_t'($urandom());
        endcase
    endfunction

    function automatic sample_t jitter(input sample_t base);
        return base + sample_t'($urandom_range(64)) - sample_t'(32);
    endfunction

    // Mostly short and medium intervals, with zero and full scale now and then
    function automatic elapsed_t pick_elapsed();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)       return '0;
        else if (pick == 1)  return DT_MAX;
        else if (pick < 8)   return elapsed_t'($urandom_range(63, 1));
        else if (pick < 14)  return elapsed_t'($urandom_range(4095, 64));
        else                 return elapsed_t'($urandom());
    endfunction

    // Offer one sample after a random gap and hold it until the transfer
    task automatic send_sample(input sample_t x, input sample_t y, input sample_t z,
                               input elapsed_t dt);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            smp.valid <= 1'b0;
            @(negedge clk);
        end
        smp.valid      <= 1'b1;
        smp.sample_x   <= x;
        smp.sample_y   <= y;
        smp.sample_z   <= z;
        smp.elapsed_us <= dt;
        @(posedge clk);
        while (!smp.ready) @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        smp.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Change tau only once every result is out
    task automatic write_tau(input logic [TAU_WIDTH-1:0] tau);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= tau;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Runs of steady input with small noise let the held values settle;
    // the rest are unrelated samples
    task automatic run_segment(input int count);
        int      done;
        int      burst;
        sample_t cx;
        sample_t cy;
        sample_t cz;
        done = 0;
        while (done < count) begin
            burst = $urandom_range(12, 1);
            if ($urandom_range(9) < 6) begin
                cx = pick_sample();
                cy = pick_sample();
                cz = pick_sample();
                repeat (burst) send_sample(jitter(cx), jitter(cy), jitter(cz), pick_elapsed());
            end else begin
                repeat (burst) send_sample(pick_sample(), pick_sample(), pick_sample(),
                                           pick_elapsed());
            end
            done += burst;
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        smp.valid      = 1'b0;
        smp.sample_x   = '0;
        smp.sample_y   = '0;
        smp.sample_z   = '0;
        smp.elapsed_us = '0;
        sender_idle_pct   = 35;
        receiver_idle_pct = 75;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset tau, zero elapsed time and full-scale swings
        send_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(0), '0);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(1), DT_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(-1), DT_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, sample_t'(0), DT_MAX);
        send_sample(sample_t'(0), sample_t'(0), sample_t'(0), elapsed_t'(1));
        send_sample(sample_t'(-1), sample_t'(1), SAMPLE_MIN, elapsed_t'(100));

        // Zero tau behaves as one: alpha close to one for long intervals
        write_tau('0);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, '0);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, elapsed_t'(1));
        send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, DT_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, DT_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, DT_MAX);
        send_sample(sample_t'(16'h5555), sample_t'(16'hAAAA), sample_t'(16'h5555),
                    elapsed_t'(16'hAAAA));
        send_sample(sample_t'(16'hAAAA), sample_t'(16'h5555), sample_t'(16'hAAAA),
                    elapsed_t'(16'h5555));

        // Largest tau: alpha small or zero
        write_tau('1);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(123), DT_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, sample_t'(-123), elapsed_t'(1));
        send_sample(sample_t'(0), sample_t'(0), sample_t'(0), '0);

        // Smallest legal tau
        write_tau(TAU_WIDTH'(1));
        send_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(-1), elapsed_t'(1));
        send_sample(SAMPLE_MIN, SAMPLE_MAX, sample_t'(0), DT_MAX);

        // Busy sender, slow receiver
        write_tau(TAU_WIDTH'($urandom_range(5000, 2)));
        hold_off_requests++;
        run_segment(SEGMENT_ITEMS);
        write_tau(TAU_WIDTH'($urandom_range(200, 1)));
        run_segment(SEGMENT_ITEMS);

        // Slow sender, busy receiver
        sender_idle_pct   = 75;
        receiver_idle_pct = 35;
        write_tau('1);
        run_segment(SEGMENT_ITEMS);
        write_tau(TAU_WIDTH'($urandom()));
        run_segment(SEGMENT_ITEMS);

        // Full rate both sides, with long output hold-offs to back up the input
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_tau(TAU_RESET);
        hold_off_requests++;
        run_segment(SEGMENT_ITEMS);
        write_tau(TAU_WIDTH'($urandom_range(100000, 1)));
        hold_off_requests++;
        run_segment(SEGMENT_ITEMS);

        // Wait out the last results, then give the verdict
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/talp_pkg.sv
rtl/talp_sample_if.sv
rtl/talp_result_if.sv
rtl/three_axis_adaptive_low_pass_core.sv
tb/talp_filter_check.sv
tb/three_axis_adaptive_low_pass_core_test.sv
